[hdl/sve_pkg.sv]
// ----------------------------------------------------------------------------
// sve_pkg
// Shared types and constants for the sprite VM instruction executor.
// ----------------------------------------------------------------------------
package sve_pkg;

	// Screen geometry; both sizes must be powers of two
	localparam int SCREEN_COLS = 64;
	localparam int SCREEN_ROWS = 32;
	localparam int COL_W       = $clog2(SCREEN_COLS);
	localparam int ROW_W       = $clog2(SCREEN_ROWS);
	localparam int MEM_BYTES   = 4096;
	localparam int ADDR_W      = $clog2(MEM_BYTES);
	localparam int STACK_DEPTH = 16;
	localparam int SP_W        = $clog2(STACK_DEPTH);

	// Item kinds
	localparam logic [1:0] FUNC_EXEC  = 2'd0;
	localparam logic [1:0] FUNC_WRMEM = 2'd1;
	localparam logic [1:0] FUNC_PIXEL = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	// Timer select codes
	localparam logic [1:0] TSEL_NONE  = 2'd0;
	localparam logic [1:0] TSEL_DELAY = 2'd1;
	localparam logic [1:0] TSEL_SOUND = 2'd2;

	// Opcode groups (top nibble)
	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JP   = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SEI  = 4'h3;
	localparam logic [3:0] OP_SNEI = 4'h4;
	localparam logic [3:0] OP_SER  = 4'h5;
	localparam logic [3:0] OP_LDI  = 4'h6;
	localparam logic [3:0] OP_ADDI = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNER = 4'h9;
	localparam logic [3:0] OP_LDIX = 4'hA;
	localparam logic [3:0] OP_JPV0 = 4'hB;
	localparam logic [3:0] OP_RND  = 4'hC;
	localparam logic [3:0] OP_DRW  = 4'hD;
	localparam logic [3:0] OP_KEY  = 4'hE;
	localparam logic [3:0] OP_MISC = 4'hF;

	localparam logic [15:0] OPC_CLS = 16'h00E0;
	localparam logic [15:0] OPC_RET = 16'h00EE;

	// ALU sub codes (low nibble of 8xyN)
	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	// Low byte codes
	localparam logic [7:0] KK_SKP  = 8'h9E;
	localparam logic [7:0] KK_SKNP = 8'hA1;
	localparam logic [7:0] KK_GDT  = 8'h07;
	localparam logic [7:0] KK_WKEY = 8'h0A;
	localparam logic [7:0] KK_SDT  = 8'h15;
	localparam logic [7:0] KK_SST  = 8'h18;
	localparam logic [7:0] KK_ADDI = 8'h1E;
	localparam logic [7:0] KK_FONT = 8'h29;
	localparam logic [7:0] KK_BCD  = 8'h33;
	localparam logic [7:0] KK_STR  = 8'h55;
	localparam logic [7:0] KK_LDR  = 8'h65;

	localparam logic [3:0] FLAG_REG = 4'hF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RDX,
		ST_RDY,
		ST_EXEC,
		ST_FLAG,
		ST_DRAW_RD,
		ST_DRAW_WR,
		ST_PIX,
		ST_BCD_H,
		ST_BCD_T,
		ST_BCD_O,
		ST_ST_RD,
		ST_ST_WR,
		ST_LD_RD,
		ST_LD_WR,
		ST_FINISH
	} state_t;

endpackage

[hdl/sve_if.sv]
// ----------------------------------------------------------------------------
// sve_if
// Request and response channels of the sprite VM executor.
// ----------------------------------------------------------------------------
interface sve_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] opcode;
	logic [15:0] key_mask;
	logic [7:0]  random_byte;
	logic [7:0]  delay_timer_value;
	logic [11:0] mem_address;
	logic [7:0]  mem_data;
	logic [5:0]  pixel_x;
	logic [4:0]  pixel_y;

	modport source (output valid, func, opcode, key_mask, random_byte, delay_timer_value,
		mem_address, mem_data, pixel_x, pixel_y, input ready);
	modport sink (input valid, func, opcode, key_mask, random_byte, delay_timer_value,
		mem_address, mem_data, pixel_x, pixel_y, output ready);
endinterface

interface sve_rsp_if;
	logic        valid;
	logic        ready;
	logic [11:0] program_counter;
	logic [11:0] index_address;
	logic [7:0]  flag_value;
	logic        waiting_key;
	logic [1:0]  timer_write;
	logic [7:0]  timer_value;
	logic        pixel_value;

	modport source (output valid, program_counter, index_address, flag_value, waiting_key,
		timer_write, timer_value, pixel_value, input ready);
	modport sink (input valid, program_counter, index_address, flag_value, waiting_key,
		timer_write, timer_value, pixel_value, output ready);
endinterface

[hdl/sprite_vm_instruction_executor_top.sv]
// ----------------------------------------------------------------------------
// sprite_vm_instruction_executor_top
// Executes one sprite VM instruction, RAM write or pixel read per beat.
// ----------------------------------------------------------------------------
// One item at a time, set by the sequencer: a new request is taken only in
// idle, after the last result has entered the output register; a result
// still waiting there holds the sequencer in its finish state.
// Reset clears registers, PC, I, SP and the screen row valid bits at once;
// RAM and return stack are not cleared.
// ----------------------------------------------------------------------------
module sprite_vm_instruction_executor_top (
	input  logic      clk,
	input  logic      arst_n,
	sve_req_if.sink   req,
	sve_rsp_if.source rsp
);

	localparam int AW = sve_pkg::ADDR_W;
	localparam int CW = sve_pkg::COL_W;
	localparam int RW = sve_pkg::ROW_W;
	localparam int NC = sve_pkg::SCREEN_COLS;
	localparam int NR = sve_pkg::SCREEN_ROWS;

	// state and architectural registers
	sve_pkg::state_t state_q, state_d;
	logic [15:0]   op_q, op_d;
	logic [15:0]   keys_q, keys_d;
	logic [7:0]    rnd_q, rnd_d;
	logic [7:0]    dt_q, dt_d;
	logic [5:0]    px_q, px_d;
	logic          pok_q, pok_d;
	logic [AW-1:0] pc_q, pc_d;
	logic [AW-1:0] i_q, i_d;
	logic [sve_pkg::SP_W-1:0] sp_q, sp_d;
	logic [7:0]    vreg_q [16];
	logic [AW-1:0] stack_q [sve_pkg::STACK_DEPTH];
	logic [7:0]    vx_q, vx_d, vy_q, vy_d;
	logic [3:0]    cnt_q, cnt_d;
	logic          hit_q, hit_d, flag_q, flag_d;
	logic [CW-1:0] ox_q, ox_d;
	logic [RW-1:0] oy_q, oy_d;
	logic [3:0]    dig_q, dig_d;
	logic [7:0]    rem_q, rem_d;
	logic          wait_q, wait_d, pix_q, pix_d;
	logic [1:0]    tsel_q, tsel_d;
	logic [7:0]    tval_q, tval_d;

	// output register
	logic          rsp_vld_q, rsp_vld_d, rsp_load;

	// register file ports
	logic [3:0]    v_ridx;
	logic [7:0]    v_rdata;
	logic          v_we;
	logic [3:0]    v_widx;
	logic [7:0]    v_wdata;
	logic          stk_we;

	// RAM
	logic [7:0]    mem [sve_pkg::MEM_BYTES];
	logic [7:0]    mem_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [7:0]    mem_wd;

	// screen
	logic [NC-1:0] scr [NR];
	logic [NC-1:0] scr_q;
	logic [RW-1:0] scr_ra_q;
	logic [NR-1:0] scr_vld_q;
	logic          scr_we, scr_re, scr_clr;
	logic [RW-1:0] scr_wa, scr_ra;
	logic [NC-1:0] scr_wd;

	// shared add/subtract unit; bit 8 is carry, or no-borrow when subtracting
	logic [7:0]    alu_a, alu_b;
	logic          alu_sub;
	logic [8:0]    alu_res;

	// decode fields
	logic [3:0]    fx, fy, fn;
	logic [7:0]    kk;
	logic [AW-1:0] nnn, pc_next, pc_skip;
	logic          key_hit;
	logic          wk_found;
	logic [3:0]    wk_key;
	logic [NC-1:0] old_row, placed;
	logic [7:0]    spr_rev;
	logic [NC+7:0] spr_wide;

	assign fx      = op_q[11:8];
	assign fy      = op_q[7:4];
	assign fn      = op_q[3:0];
	assign kk      = op_q[7:0];
	assign nnn     = op_q[AW-1:0];
	assign pc_next = pc_q + AW'(2);
	assign pc_skip = pc_q + AW'(4);
	assign v_rdata = vreg_q[v_ridx];
	assign key_hit = (vx_q < 8'd16) && keys_q[vx_q[3:0]];

	assign alu_res = alu_sub ? ({1'b0, alu_a} + {1'b0, ~alu_b} + 9'd1)
		: ({1'b0, alu_a} + {1'b0, alu_b});

	// highest pressed key
	always_comb begin
		wk_found = 1'b0;
		wk_key   = 4'd0;
		for (int k = 0; k < 16; k++) begin
			if (keys_q[k]) begin
				wk_found = 1'b1;
				wk_key   = 4'(k);
			end
		end
	end

	// sprite row placed at its column; bits past the right edge drop off
	always_comb begin
		for (int c = 0; c < 8; c++) begin
			spr_rev[c] = mem_q[7 - c];
		end
		spr_wide = (NC + 8)'(spr_rev) << ox_q;
		placed   = spr_wide[NC-1:0];
		old_row  = scr_vld_q[scr_ra_q] ? scr_q : '0;
	end

	assign req.ready = (state_q == sve_pkg::ST_IDLE);
	assign rsp_load  = (state_q == sve_pkg::ST_FINISH) && (!rsp_vld_q || rsp.ready);

	// sequencer: next state and datapath controls
	always_comb begin
		state_d = state_q;
		op_d = op_q; keys_d = keys_q; rnd_d = rnd_q; dt_d = dt_q;
		px_d = px_q; pok_d = pok_q;
		pc_d = pc_q; i_d = i_q; sp_d = sp_q;
		vx_d = vx_q; vy_d = vy_q; cnt_d = cnt_q; hit_d = hit_q; flag_d = flag_q;
		ox_d = ox_q; oy_d = oy_q; dig_d = dig_q; rem_d = rem_q;
		wait_d = wait_q; pix_d = pix_q; tsel_d = tsel_q; tval_d = tval_q;
		rsp_vld_d = rsp_vld_q && !rsp.ready;
		v_ridx = fx;
		v_we = 1'b0; v_widx = fx; v_wdata = 8'd0;
		stk_we = 1'b0;
		mem_we = 1'b0; mem_wa = i_q; mem_wd = 8'd0;
		mem_re = 1'b0; mem_ra = i_q + AW'(cnt_q);
		scr_we = 1'b0; scr_wa = scr_ra_q; scr_wd = old_row ^ placed;
		scr_re = 1'b0; scr_ra = RW'(32'(oy_q) + 32'(cnt_q));
		scr_clr = 1'b0;
		alu_a = vx_q; alu_b = vy_q; alu_sub = 1'b0;

		case (state_q)
			sve_pkg::ST_IDLE: begin
				if (req.valid) begin
					op_d = req.opcode; keys_d = req.key_mask;
					rnd_d = req.random_byte; dt_d = req.delay_timer_value;
					px_d = req.pixel_x;
					pok_d = (32'(req.pixel_x) < NC) && (32'(req.pixel_y) < NR);
					wait_d = 1'b0; pix_d = 1'b0;
					tsel_d = sve_pkg::TSEL_NONE; tval_d = 8'd0;
					case (req.func)
						sve_pkg::FUNC_EXEC: state_d = sve_pkg::ST_RDX;
						sve_pkg::FUNC_WRMEM: begin
							mem_we  = 1'b1;
							mem_wa  = req.mem_address;
							mem_wd  = req.mem_data;
							state_d = sve_pkg::ST_FINISH;
						end
						sve_pkg::FUNC_PIXEL: begin
							scr_re  = 1'b1;
							scr_ra  = RW'(req.pixel_y);
							state_d = sve_pkg::ST_PIX;
						end
						default: state_d = sve_pkg::ST_FINISH;
					endcase
				end
			end
			sve_pkg::ST_RDX: begin
				v_ridx  = fx;
				vx_d    = v_rdata;
				state_d = sve_pkg::ST_RDY;
			end
			sve_pkg::ST_RDY: begin
				v_ridx  = (op_q[15:12] == sve_pkg::OP_JPV0) ? 4'd0 : fy;
				vy_d    = v_rdata;
				state_d = sve_pkg::ST_EXEC;
			end
			sve_pkg::ST_EXEC: begin
				pc_d    = pc_next;
				state_d = sve_pkg::ST_FINISH;
				case (op_q[15:12])
					sve_pkg::OP_SYS: begin
						if (op_q == sve_pkg::OPC_CLS) begin
							scr_clr = 1'b1;
						end else if (op_q == sve_pkg::OPC_RET) begin
							pc_d = stack_q[sp_q] + AW'(2);
							sp_d = sp_q - sve_pkg::SP_W'(1);
						end
					end
					sve_pkg::OP_JP: pc_d = nnn;
					sve_pkg::OP_CALL: begin
						sp_d   = sp_q + sve_pkg::SP_W'(1);
						stk_we = 1'b1;
						pc_d   = nnn;
					end
					sve_pkg::OP_SEI:  if (vx_q == kk) pc_d = pc_skip;
					sve_pkg::OP_SNEI: if (vx_q != kk) pc_d = pc_skip;
					sve_pkg::OP_SER:  if (fn == 4'd0 && vx_q == vy_q) pc_d = pc_skip;
					sve_pkg::OP_SNER: if (fn == 4'd0 && vx_q != vy_q) pc_d = pc_skip;
					sve_pkg::OP_LDI: begin
						v_we = 1'b1; v_wdata = kk;
					end
					sve_pkg::OP_ADDI: begin
						alu_b = kk;
						v_we = 1'b1; v_wdata = alu_res[7:0];
					end
					sve_pkg::OP_ALU: begin
						// result first, flag in the following cycle
						state_d = sve_pkg::ST_FLAG;
						flag_d  = 1'b0;
						v_we    = 1'b1;
						case (fn)
							sve_pkg::ALU_MOV: begin
								v_wdata = vy_q; state_d = sve_pkg::ST_FINISH;
							end
							sve_pkg::ALU_OR:  v_wdata = vx_q | vy_q;
							sve_pkg::ALU_AND: v_wdata = vx_q & vy_q;
							sve_pkg::ALU_XOR: v_wdata = vx_q ^ vy_q;
							sve_pkg::ALU_ADD: begin
								v_wdata = alu_res[7:0]; flag_d = alu_res[8];
							end
							sve_pkg::ALU_SUB: begin
								alu_sub = 1'b1;
								v_wdata = alu_res[7:0]; flag_d = alu_res[8];
							end
							sve_pkg::ALU_SBN: begin
								alu_a = vy_q; alu_b = vx_q; alu_sub = 1'b1;
								v_wdata = alu_res[7:0]; flag_d = alu_res[8];
							end
							sve_pkg::ALU_SHR: begin
								v_wdata = {1'b0, vx_q[7:1]}; flag_d = vx_q[0];
							end
							sve_pkg::ALU_SHL: begin
								v_wdata = {vx_q[6:0], 1'b0}; flag_d = vx_q[7];
							end
							default: begin
								v_we = 1'b0; state_d = sve_pkg::ST_FINISH;
							end
						endcase
					end
					sve_pkg::OP_LDIX: i_d = nnn;
					sve_pkg::OP_JPV0: pc_d = nnn + AW'(vy_q);
					sve_pkg::OP_RND: begin
						v_we = 1'b1; v_wdata = rnd_q & kk;
					end
					sve_pkg::OP_DRW: begin
						ox_d  = CW'(vx_q % NC);
						oy_d  = RW'(vy_q % NR);
						cnt_d = 4'd0;
						hit_d = 1'b0;
						if (fn == 4'd0) begin
							v_we = 1'b1; v_widx = sve_pkg::FLAG_REG; v_wdata = 8'd0;
						end else begin
							state_d = sve_pkg::ST_DRAW_RD;
						end
					end
					sve_pkg::OP_KEY: begin
						if (kk == sve_pkg::KK_SKP) begin
							if (key_hit) pc_d = pc_skip;
						end else if (kk == sve_pkg::KK_SKNP) begin
							if (!key_hit) pc_d = pc_skip;
						end
					end
					default: begin
						case (kk)
							sve_pkg::KK_GDT: begin
								v_we = 1'b1; v_wdata = dt_q;
							end
							sve_pkg::KK_WKEY: begin
								if (wk_found) begin
									v_we = 1'b1; v_wdata = {4'd0, wk_key};
								end else begin
									pc_d = pc_q; wait_d = 1'b1;
								end
							end
							sve_pkg::KK_SDT: begin
								tsel_d = sve_pkg::TSEL_DELAY; tval_d = vx_q;
							end
							sve_pkg::KK_SST: begin
								tsel_d = sve_pkg::TSEL_SOUND; tval_d = vx_q;
							end
							sve_pkg::KK_ADDI: i_d = i_q + AW'(vx_q);
							sve_pkg::KK_FONT: i_d = AW'({2'b00, vx_q, 2'b00} + {4'd0, vx_q});
							sve_pkg::KK_BCD: begin
								rem_d = vx_q; dig_d = 4'd0; state_d = sve_pkg::ST_BCD_H;
							end
							sve_pkg::KK_STR: begin
								cnt_d = 4'd0; state_d = sve_pkg::ST_ST_RD;
							end
							sve_pkg::KK_LDR: begin
								cnt_d = 4'd0; state_d = sve_pkg::ST_LD_RD;
							end
							default: ;
						endcase
					end
				endcase
			end
			sve_pkg::ST_FLAG: begin
				v_we = 1'b1; v_widx = sve_pkg::FLAG_REG; v_wdata = {7'd0, flag_q};
				state_d = sve_pkg::ST_FINISH;
			end
			// draw: fetch sprite byte and screen row, then merge
			sve_pkg::ST_DRAW_RD: begin
				if (cnt_q < fn && (32'(oy_q) + 32'(cnt_q)) < NR) begin
					mem_re  = 1'b1;
					scr_re  = 1'b1;
					state_d = sve_pkg::ST_DRAW_WR;
				end else begin
					v_we = 1'b1; v_widx = sve_pkg::FLAG_REG; v_wdata = {7'd0, hit_q};
					state_d = sve_pkg::ST_FINISH;
				end
			end
			sve_pkg::ST_DRAW_WR: begin
				scr_we  = 1'b1;
				hit_d   = hit_q | (|(old_row & placed));
				cnt_d   = cnt_q + 4'd1;
				state_d = sve_pkg::ST_DRAW_RD;
			end
			sve_pkg::ST_PIX: begin
				pix_d   = pok_q && scr_vld_q[scr_ra_q] && scr_q[CW'(px_q)];
				state_d = sve_pkg::ST_FINISH;
			end
			// BCD by repeated subtraction on the shared unit
			sve_pkg::ST_BCD_H: begin
				alu_a = rem_q; alu_b = 8'd100; alu_sub = 1'b1;
				if (alu_res[8]) begin
					rem_d = alu_res[7:0]; dig_d = dig_q + 4'd1;
				end else begin
					mem_we = 1'b1; mem_wa = i_q; mem_wd = {4'd0, dig_q};
					dig_d = 4'd0; state_d = sve_pkg::ST_BCD_T;
				end
			end
			sve_pkg::ST_BCD_T: begin
				alu_a = rem_q; alu_b = 8'd10; alu_sub = 1'b1;
				if (alu_res[8]) begin
					rem_d = alu_res[7:0]; dig_d = dig_q + 4'd1;
				end else begin
					mem_we = 1'b1; mem_wa = i_q + AW'(1); mem_wd = {4'd0, dig_q};
					state_d = sve_pkg::ST_BCD_O;
				end
			end
			sve_pkg::ST_BCD_O: begin
				mem_we = 1'b1; mem_wa = i_q + AW'(2); mem_wd = rem_q;
				state_d = sve_pkg::ST_FINISH;
			end
			// block store V0..Vx
			sve_pkg::ST_ST_RD: begin
				v_ridx  = cnt_q;
				vy_d    = v_rdata;
				state_d = sve_pkg::ST_ST_WR;
			end
			sve_pkg::ST_ST_WR: begin
				mem_we = 1'b1; mem_wa = i_q + AW'(cnt_q); mem_wd = vy_q;
				cnt_d  = cnt_q + 4'd1;
				state_d = (cnt_q == fx) ? sve_pkg::ST_FINISH : sve_pkg::ST_ST_RD;
			end
			// block load V0..Vx
			sve_pkg::ST_LD_RD: begin
				mem_re  = 1'b1;
				state_d = sve_pkg::ST_LD_WR;
			end
			sve_pkg::ST_LD_WR: begin
				v_we = 1'b1; v_widx = cnt_q; v_wdata = mem_q;
				cnt_d  = cnt_q + 4'd1;
				state_d = (cnt_q == fx) ? sve_pkg::ST_FINISH : sve_pkg::ST_LD_RD;
			end
			sve_pkg::ST_FINISH: begin
				if (rsp_load) begin
					rsp_vld_d = 1'b1;
					state_d   = sve_pkg::ST_IDLE;
				end
			end
			default: state_d = sve_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sve_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			i_q       <= '0;
			sp_q      <= '0;
			rsp_vld_q <= 1'b0;
			scr_vld_q <= '0;
			for (int r = 0; r < 16; r++) vreg_q[r] <= 8'd0;
		end else begin
			pc_q      <= pc_d;
			i_q       <= i_d;
			sp_q      <= sp_d;
			rsp_vld_q <= rsp_vld_d;
			if (v_we) vreg_q[v_widx] <= v_wdata;
			if (scr_clr) begin
				scr_vld_q <= '0;
			end else if (scr_we) begin
				scr_vld_q[scr_wa] <= 1'b1;
			end
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		op_q <= op_d; keys_q <= keys_d; rnd_q <= rnd_d; dt_q <= dt_d;
		px_q <= px_d; pok_q <= pok_d;
		vx_q <= vx_d; vy_q <= vy_d; cnt_q <= cnt_d; hit_q <= hit_d; flag_q <= flag_d;
		ox_q <= ox_d; oy_q <= oy_d; dig_q <= dig_d; rem_q <= rem_d;
		wait_q <= wait_d; pix_q <= pix_d; tsel_q <= tsel_d; tval_q <= tval_d;
		if (stk_we) stack_q[sp_d] <= pc_q;
	end

	// RAM: one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) mem_q <= mem[mem_ra];
	end

	// screen rows: one write and one registered read port
	always_ff @(posedge clk) begin
		if (scr_we) scr[scr_wa] <= scr_wd;
		if (scr_re) begin
			scr_q    <= scr[scr_ra];
			scr_ra_q <= scr_ra;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp.program_counter <= pc_q;
			rsp.index_address   <= i_q;
			rsp.flag_value      <= vreg_q[sve_pkg::FLAG_REG];
			rsp.waiting_key     <= wait_q;
			rsp.timer_write     <= tsel_q;
			rsp.timer_value     <= tval_q;
			rsp.pixel_value     <= pix_q;
		end
	end

	assign rsp.valid = rsp_vld_q;

endmodule
